@@ design/ddo_pkg.sv @@
package ddo_pkg;

    // word and field widths
    localparam int WORD_W    = 32;
    localparam int HEAD_W    = 19;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b1;

    localparam logic [CFG_W-1:0] TRACK_RESET  = 31'd10486;
    localparam logic [CFG_W-1:0] RADIUS_RESET = 31'd2163;

    // command codes
    localparam logic CMD_WHEEL = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    // angle constants, q16.16
    localparam logic signed [20:0] PI_Q21     = 21'sd205887;
    localparam logic signed [20:0] NEG_PI_Q21 = -21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q21 = 21'sd411774;
    localparam logic [63:0]        TWO_PI_64  = 64'd411774;
    localparam logic signed [18:0] ONE_Q      = 19'sd65536;

    // cordic constants, q2.30
    localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
    localparam logic signed [33:0] PI30         = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI30    = 34'sd1686629713;
    localparam logic signed [33:0] NEG_HALF_PI30 = -34'sd1686629713;
    localparam logic [4:0]         COR_STEPS    = 5'd30;
    localparam logic [4:0]         COR_LOAD     = 5'd31;

    // serial divider length and body travel limit
    localparam logic [6:0]  DIV_STEPS = 7'd64;
    localparam logic [63:0] ARC_LIM   = 64'd35184372088832;

    localparam logic signed [49:0] WORD_MAX50 = 50'sd2147483647;
    localparam logic signed [49:0] WORD_MIN50 = -50'sd2147483648;
    localparam logic [31:0]        WORD_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0]        WORD_MIN   = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_W_MUL,
        ST_W_DIV,
        ST_V_MUL,
        ST_M_DIV,
        ST_A_COR,
        ST_ARC_LD,
        ST_XB_MUL,
        ST_XB_DIV,
        ST_YB_MUL,
        ST_YB_DIV,
        ST_H_COR,
        ST_ROT_LD,
        ST_RX1,
        ST_RX2,
        ST_POS_X,
        ST_RY1,
        ST_RY2,
        ST_POS_Y,
        ST_FINISH
    } state_t;

    // arctangent of 2^-i in q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] a;
        a = '0;
        case (i)
            5'd0:  a = 30'd843314856;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043836;
            5'd3:  a = 30'd133525158;
            5'd4:  a = 30'd67021686;
            5'd5:  a = 30'd33543515;
            5'd6:  a = 30'd16775850;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194282;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048575;
            5'd11: a = 30'd524287;
            5'd12: a = 30'd262143;
            5'd13: a = 30'd131071;
            5'd14: a = 30'd65535;
            5'd15: a = 30'd32767;
            5'd16: a = 30'd16383;
            5'd17: a = 30'd8191;
            5'd18: a = 30'd4095;
            5'd19: a = 30'd2047;
            5'd20: a = 30'd1023;
            5'd21: a = 30'd511;
            5'd22: a = 30'd255;
            5'd23: a = 30'd127;
            5'd24: a = 30'd63;
            5'd25: a = 30'd31;
            5'd26: a = 30'd15;
            5'd27: a = 30'd8;
            5'd28: a = 30'd4;
            5'd29: a = 30'd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    // fold an angle in [-3pi,3pi) into [-pi,pi)
    function automatic logic signed [18:0] wrap_pi(input logic signed [20:0] a);
        logic signed [20:0] m;
        m = a;
        if (a >= PI_Q21) begin
            m = a - TWO_PI_Q21;
        end
        else if (a < NEG_PI_Q21) begin
            m = a + TWO_PI_Q21;
        end
        return m[18:0];
    endfunction

    // q2.30 to q16.16, round half up, clamp to [-1,1]
    function automatic logic signed [17:0] to_q(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [20:0] r;
        logic signed [20:0] lim;
        lim = 21'sd65536;
        t = {v[33], v} + 35'sd8192;
        r = t[34:14];
        if (r > lim) begin
            r = lim;
        end
        else if (r < -lim) begin
            r = -lim;
        end
        return r[17:0];
    endfunction

endpackage

@@ design/ddo_if.sv @@
interface ddo_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [ddo_pkg::WORD_W-1:0]    left_wheel_angle;
    logic signed [ddo_pkg::WORD_W-1:0]    right_wheel_angle;
    logic signed [ddo_pkg::WORD_W-1:0]    new_x;
    logic signed [ddo_pkg::WORD_W-1:0]    new_y;
    logic signed [ddo_pkg::HEAD_W-1:0]    new_heading;

    modport source (
        output valid, cmd, left_wheel_angle, right_wheel_angle, new_x, new_y, new_heading,
        input  ready
    );
    modport sink (
        input  valid, cmd, left_wheel_angle, right_wheel_angle, new_x, new_y, new_heading,
        output ready
    );
endinterface

interface ddo_pose_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ddo_pkg::WORD_W-1:0]    pose_x;
    logic signed [ddo_pkg::WORD_W-1:0]    pose_y;
    logic signed [ddo_pkg::HEAD_W-1:0]    heading;

    modport source (
        output valid, pose_x, pose_y, heading,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, heading,
        output ready
    );
endinterface

@@ design/diff_drive_odometry.sv @@
// set pose: idle goes to finish, which stages the pose once the output is free
// wheel update: uses the bit-serial multiplier (one multiplier bit a cycle),
//   the 64-step restoring divider (at most four divisions) and the 30-step
//   cordic, run at most twice
// throughput: one transaction at a time, the next is taken once the pose is staged
// reset: pose, wheel angles and heading clear to zero, registers take their defaults
module diff_drive_odometry (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]         cfg_data,
    ddo_cmd_if.sink                           cmd_ch,
    ddo_pose_if.source                        pose_ch
);

    // control and model state
    ddo_pkg::state_t      state_reg, state_next;
    logic [30:0]          trk_reg, rad_reg;
    logic signed [31:0]   x_reg, x_next;
    logic signed [31:0]   y_reg, y_next;
    logic signed [18:0]   hd_reg, hd_next;
    logic [31:0]          last_l_reg, last_l_next;
    logic [31:0]          last_r_reg, last_r_next;
    logic                 ov_reg, ov_next;

    // datapath
    logic [31:0]          dl_reg, dl_next, dr_reg, dr_next;
    logic signed [32:0]   ds_reg, ds_next;
    logic                 wneg_reg, wneg_next;
    logic [62:0]          wm_reg, wm_next;
    logic [45:0]          vm_reg, vm_next;
    logic                 vn_reg, vn_next;
    logic signed [18:0]   ww_reg, ww_next;
    logic signed [17:0]   s_reg, s_next, c_reg, c_next;
    logic signed [17:0]   hs_reg, hs_next, hc_reg, hc_next;
    logic [45:0]          xbm_reg, xbm_next, ybm_reg, ybm_next;
    logic                 xbn_reg, xbn_next, ybn_reg, ybn_next;
    logic signed [63:0]   t_reg, t_next;
    logic [63:0]          acc_reg, acc_next, mc_reg, mc_next, mp_reg, mp_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic signed [18:0]   ang_reg, ang_next;
    logic signed [33:0]   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [4:0]           ci_reg, ci_next;
    logic                 flip_reg, flip_next;
    logic signed [31:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic signed [18:0]   oh_reg, oh_next;

    // combinational helpers
    logic [30:0]          trk_eff;
    logic [63:0]          mul_sum, div_t, div_rem, vm_up;
    logic                 div_ge, mul_done, div_done, cor_done, out_free;
    logic signed [32:0]   dd, ds;
    logic [32:0]          dd_abs, ds_abs;
    logic signed [33:0]   cx_sh, cy_sh, z0, cz_fold, atan_ext;
    logic                 fold_flip;
    logic signed [17:0]   cor_s, cor_c;
    logic [17:0]          s_abs, hs_abs, hc_abs, one_minus_c;
    logic signed [18:0]   one_minus_wide;
    logic [45:0]          q_clamp;
    logic signed [20:0]   rem_s, hd_sum;
    logic signed [31:0]   pos_base, pos_sat;
    logic signed [49:0]   pos_sum;

    // a zero track behaves as one
    assign trk_eff = (trk_reg == '0) ? 31'd1 : trk_reg;

    assign cmd_ch.ready    = (state_reg == ddo_pkg::ST_IDLE);
    assign pose_ch.valid   = ov_reg;
    assign pose_ch.pose_x  = ox_reg;
    assign pose_ch.pose_y  = oy_reg;
    assign pose_ch.heading = oh_reg;
    assign out_free        = !ov_reg || pose_ch.ready;

    // serial multiplier: one multiplier bit a cycle, done when none are left
    assign mul_sum  = mp_reg[0] ? acc_reg + mc_reg : acc_reg;
    assign mul_done = (mp_reg == '0);

    // restoring divider: dividend bits shift out of mp, quotient bits shift in
    assign div_t    = {acc_reg[62:0], mp_reg[63]};
    assign div_ge   = (div_t >= mc_reg);
    assign div_rem  = div_ge ? div_t - mc_reg : div_t;
    assign div_done = (cnt_reg == ddo_pkg::DIV_STEPS);

    // wheel differences and their sum and difference
    assign dd     = $signed({dr_reg[31], dr_reg}) - $signed({dl_reg[31], dl_reg});
    assign ds     = $signed({dl_reg[31], dl_reg}) + $signed({dr_reg[31], dr_reg});
    assign dd_abs = dd[32] ? 33'(-dd) : 33'(dd);
    assign ds_abs = ds_reg[32] ? 33'(-ds_reg) : 33'(ds_reg);

    // travel magnitude: floor of a negative product rounds its magnitude up
    assign vm_up  = acc_reg + 64'd131071;

    // cordic: fold into [-pi/2,pi/2], then one rotation a cycle
    assign z0       = {ang_reg[18], ang_reg, 14'b0};
    assign cx_sh    = cx_reg >>> ci_reg;
    assign cy_sh    = cy_reg >>> ci_reg;
    assign atan_ext = $signed({4'b0, ddo_pkg::atan_q30(ci_reg)});
    assign cor_done = (ci_reg == ddo_pkg::COR_STEPS);
    assign cor_s    = ddo_pkg::to_q(flip_reg ? -cy_reg : cy_reg);
    assign cor_c    = ddo_pkg::to_q(flip_reg ? -cx_reg : cx_reg);

    always_comb
    begin
        fold_flip = 1'b0;
        cz_fold   = z0;
        if (z0 > ddo_pkg::HALF_PI30)
        begin
            cz_fold   = z0 - ddo_pkg::PI30;
            fold_flip = 1'b1;
        end
        else if (z0 < ddo_pkg::NEG_HALF_PI30)
        begin
            cz_fold   = z0 + ddo_pkg::PI30;
            fold_flip = 1'b1;
        end
    end

    assign s_abs  = s_reg[17] ? 18'(-s_reg) : 18'(s_reg);
    assign hs_abs = hs_reg[17] ? 18'(-hs_reg) : 18'(hs_reg);
    assign hc_abs = hc_reg[17] ? 18'(-hc_reg) : 18'(hc_reg);
    assign one_minus_wide = ddo_pkg::ONE_Q - {c_reg[17], c_reg};
    assign one_minus_c    = one_minus_wide[17:0];

    // body travel is clamped to 2^45 in magnitude
    assign q_clamp = (mp_reg > ddo_pkg::ARC_LIM) ? ddo_pkg::ARC_LIM[45:0] : mp_reg[45:0];

    // remainder of the rotation by a full turn, sign of the dividend
    assign rem_s  = wneg_reg ? -$signed({2'b0, acc_reg[18:0]}) : $signed({2'b0, acc_reg[18:0]});
    assign hd_sum = $signed({{2{hd_reg[18]}}, hd_reg}) + $signed({{2{ww_reg[18]}}, ww_reg});

    // pose update with saturation
    assign pos_base = (state_reg == ddo_pkg::ST_POS_X) ? x_reg : y_reg;
    assign pos_sum  = $signed({{18{pos_base[31]}}, pos_base}) + $signed({{2{t_reg[63]}}, t_reg[63:16]});
    always_comb
    begin
        if (pos_sum > ddo_pkg::WORD_MAX50)
        begin
            pos_sat = ddo_pkg::WORD_MAX;
        end
        else if (pos_sum < ddo_pkg::WORD_MIN50)
        begin
            pos_sat = ddo_pkg::WORD_MIN;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    state_next = (cmd_ch.cmd == ddo_pkg::CMD_SET) ? ddo_pkg::ST_FINISH
                                                                  : ddo_pkg::ST_PREP;
                end
            end
            ddo_pkg::ST_PREP:   state_next = ddo_pkg::ST_W_MUL;
            ddo_pkg::ST_W_MUL:  if (mul_done) state_next = ddo_pkg::ST_W_DIV;
            ddo_pkg::ST_W_DIV:  if (div_done) state_next = ddo_pkg::ST_V_MUL;
            ddo_pkg::ST_V_MUL:
            begin
                if (mul_done)
                begin
                    state_next = (wm_reg == '0) ? ddo_pkg::ST_H_COR : ddo_pkg::ST_M_DIV;
                end
            end
            ddo_pkg::ST_M_DIV:  if (div_done) state_next = ddo_pkg::ST_A_COR;
            ddo_pkg::ST_A_COR:  if (cor_done) state_next = ddo_pkg::ST_ARC_LD;
            ddo_pkg::ST_ARC_LD: state_next = ddo_pkg::ST_XB_MUL;
            ddo_pkg::ST_XB_MUL: if (mul_done) state_next = ddo_pkg::ST_XB_DIV;
            ddo_pkg::ST_XB_DIV: if (div_done) state_next = ddo_pkg::ST_YB_MUL;
            ddo_pkg::ST_YB_MUL: if (mul_done) state_next = ddo_pkg::ST_YB_DIV;
            ddo_pkg::ST_YB_DIV: if (div_done) state_next = ddo_pkg::ST_H_COR;
            ddo_pkg::ST_H_COR:  if (cor_done) state_next = ddo_pkg::ST_ROT_LD;
            ddo_pkg::ST_ROT_LD: state_next = ddo_pkg::ST_RX1;
            ddo_pkg::ST_RX1:    if (mul_done) state_next = ddo_pkg::ST_RX2;
            ddo_pkg::ST_RX2:    if (mul_done) state_next = ddo_pkg::ST_POS_X;
            ddo_pkg::ST_POS_X:  state_next = ddo_pkg::ST_RY1;
            ddo_pkg::ST_RY1:    if (mul_done) state_next = ddo_pkg::ST_RY2;
            ddo_pkg::ST_RY2:    if (mul_done) state_next = ddo_pkg::ST_POS_Y;
            ddo_pkg::ST_POS_Y:  state_next = ddo_pkg::ST_FINISH;
            ddo_pkg::ST_FINISH: if (out_free) state_next = ddo_pkg::ST_IDLE;
            default:            state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        x_next = x_reg;       y_next = y_reg;       hd_next = hd_reg;
        last_l_next = last_l_reg;   last_r_next = last_r_reg;
        dl_next = dl_reg;     dr_next = dr_reg;     ds_next = ds_reg;
        wneg_next = wneg_reg; wm_next = wm_reg;
        vm_next = vm_reg;     vn_next = vn_reg;     ww_next = ww_reg;
        s_next = s_reg;       c_next = c_reg;       hs_next = hs_reg;  hc_next = hc_reg;
        xbm_next = xbm_reg;   ybm_next = ybm_reg;   xbn_next = xbn_reg; ybn_next = ybn_reg;
        t_next = t_reg;
        acc_next = acc_reg;   mc_next = mc_reg;     mp_next = mp_reg;  cnt_next = cnt_reg;
        ang_next = ang_reg;
        cx_next = cx_reg;     cy_next = cy_reg;     cz_next = cz_reg;
        ci_next = ci_reg;     flip_next = flip_reg;
        ox_next = ox_reg;     oy_next = oy_reg;     oh_next = oh_reg;
        ov_next = ov_reg && !pose_ch.ready;

        // multiply, divide and cordic steps shared by all states that run them
        case (state_reg)
            ddo_pkg::ST_W_MUL, ddo_pkg::ST_V_MUL, ddo_pkg::ST_XB_MUL, ddo_pkg::ST_YB_MUL,
            ddo_pkg::ST_RX1, ddo_pkg::ST_RX2, ddo_pkg::ST_RY1, ddo_pkg::ST_RY2:
            begin
                if (!mul_done)
                begin
                    acc_next = mul_sum;
                    mc_next  = {mc_reg[62:0], 1'b0};
                    mp_next  = {1'b0, mp_reg[63:1]};
                end
            end
            ddo_pkg::ST_W_DIV, ddo_pkg::ST_M_DIV, ddo_pkg::ST_XB_DIV, ddo_pkg::ST_YB_DIV:
            begin
                if (!div_done)
                begin
                    acc_next = div_rem;
                    mp_next  = {mp_reg[62:0], div_ge};
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ddo_pkg::ST_A_COR, ddo_pkg::ST_H_COR:
            begin
                if (ci_reg == ddo_pkg::COR_LOAD)
                begin
                    cx_next   = ddo_pkg::CORDIC_K;
                    cy_next   = '0;
                    cz_next   = cz_fold;
                    flip_next = fold_flip;
                    ci_next   = '0;
                end
                else if (!cor_done)
                begin
                    if (!cz_reg[33])
                    begin
                        cx_next = cx_reg - cy_sh;
                        cy_next = cy_reg + cx_sh;
                        cz_next = cz_reg - atan_ext;
                    end
                    else
                    begin
                        cx_next = cx_reg + cy_sh;
                        cy_next = cy_reg - cx_sh;
                        cz_next = cz_reg + atan_ext;
                    end
                    ci_next = ci_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase

        // completions and operand loads
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    if (cmd_ch.cmd == ddo_pkg::CMD_SET)
                    begin
                        x_next  = cmd_ch.new_x;
                        y_next  = cmd_ch.new_y;
                        hd_next = ddo_pkg::wrap_pi({{2{cmd_ch.new_heading[18]}},
                                                    cmd_ch.new_heading});
                    end
                    else
                    begin
                        // wrapping 32-bit differences from the stored angles
                        dl_next     = cmd_ch.left_wheel_angle - last_l_reg;
                        dr_next     = cmd_ch.right_wheel_angle - last_r_reg;
                        last_l_next = cmd_ch.left_wheel_angle;
                        last_r_next = cmd_ch.right_wheel_angle;
                    end
                end
            end
            ddo_pkg::ST_PREP:
            begin
                // radius times (dr - dl)
                ds_next   = ds;
                wneg_next = dd[32];
                acc_next  = '0;
                mc_next   = {33'b0, rad_reg};
                mp_next   = {31'b0, dd_abs};
            end
            ddo_pkg::ST_W_MUL:
            begin
                if (mul_done)
                begin
                    // divide by the track
                    acc_next = '0;
                    mp_next  = acc_reg;
                    mc_next  = {33'b0, trk_eff};
                    cnt_next = '0;
                end
            end
            ddo_pkg::ST_W_DIV:
            begin
                if (div_done)
                begin
                    wm_next  = mp_reg[62:0];
                    acc_next = '0;
                    mc_next  = {33'b0, rad_reg};
                    mp_next  = {31'b0, ds_abs};
                end
            end
            ddo_pkg::ST_V_MUL:
            begin
                if (mul_done)
                begin
                    vm_next = ds_reg[32] ? vm_up[62:17] : acc_reg[62:17];
                    vn_next = ds_reg[32] && (acc_reg != '0);
                    if (wm_reg == '0)
                    begin
                        // straight line: forward travel only
                        xbm_next = ds_reg[32] ?
                                   ((vm_up[63:17] > ddo_pkg::ARC_LIM[46:0]) ?
                                    ddo_pkg::ARC_LIM[45:0] : vm_up[62:17]) :
                                   ((acc_reg[63:17] > ddo_pkg::ARC_LIM[46:0]) ?
                                    ddo_pkg::ARC_LIM[45:0] : acc_reg[62:17]);
                        xbn_next = ds_reg[32] && (acc_reg != '0);
                        ybm_next = '0;
                        ybn_next = 1'b0;
                        ww_next  = '0;
                        ang_next = hd_reg;
                        ci_next  = ddo_pkg::COR_LOAD;
                    end
                    else
                    begin
                        // rotation modulo a full turn
                        acc_next = '0;
                        mp_next  = {1'b0, wm_reg};
                        mc_next  = ddo_pkg::TWO_PI_64;
                        cnt_next = '0;
                    end
                end
            end
            ddo_pkg::ST_M_DIV:
            begin
                if (div_done)
                begin
                    ww_next  = ddo_pkg::wrap_pi(rem_s);
                    ang_next = ddo_pkg::wrap_pi(rem_s);
                    ci_next  = ddo_pkg::COR_LOAD;
                end
            end
            ddo_pkg::ST_A_COR:
            begin
                if (cor_done)
                begin
                    s_next = cor_s;
                    c_next = cor_c;
                end
            end
            ddo_pkg::ST_ARC_LD:
            begin
                // |v| * |sin w|
                acc_next = '0;
                mc_next  = {18'b0, vm_reg};
                mp_next  = {46'b0, s_abs};
            end
            ddo_pkg::ST_XB_MUL, ddo_pkg::ST_YB_MUL:
            begin
                if (mul_done)
                begin
                    acc_next = '0;
                    mp_next  = acc_reg;
                    mc_next  = {1'b0, wm_reg};
                    cnt_next = '0;
                end
            end
            ddo_pkg::ST_XB_DIV:
            begin
                if (div_done)
                begin
                    xbm_next = q_clamp;
                    xbn_next = vn_reg ^ s_reg[17] ^ wneg_reg;
                    // |v| * (1 - cos w)
                    acc_next = '0;
                    mc_next  = {18'b0, vm_reg};
                    mp_next  = {46'b0, one_minus_c};
                end
            end
            ddo_pkg::ST_YB_DIV:
            begin
                if (div_done)
                begin
                    ybm_next = q_clamp;
                    ybn_next = vn_reg ^ wneg_reg;
                    ang_next = hd_reg;
                    ci_next  = ddo_pkg::COR_LOAD;
                end
            end
            ddo_pkg::ST_H_COR:
            begin
                if (cor_done)
                begin
                    hs_next = cor_s;
                    hc_next = cor_c;
                end
            end
            ddo_pkg::ST_ROT_LD:
            begin
                acc_next = '0;
                mc_next  = {18'b0, xbm_reg};
                mp_next  = {46'b0, hc_abs};
            end
            ddo_pkg::ST_RX1:
            begin
                if (mul_done)
                begin
                    t_next   = (xbn_reg ^ hc_reg[17]) ? -$signed(acc_reg) : $signed(acc_reg);
                    acc_next = '0;
                    mc_next  = {18'b0, ybm_reg};
                    mp_next  = {46'b0, hs_abs};
                end
            end
            ddo_pkg::ST_RX2:
            begin
                if (mul_done)
                begin
                    t_next = (ybn_reg ^ hs_reg[17]) ? t_reg + $signed(acc_reg)
                                                    : t_reg - $signed(acc_reg);
                end
            end
            ddo_pkg::ST_POS_X:
            begin
                x_next   = pos_sat;
                acc_next = '0;
                mc_next  = {18'b0, xbm_reg};
                mp_next  = {46'b0, hs_abs};
            end
            ddo_pkg::ST_RY1:
            begin
                if (mul_done)
                begin
                    t_next   = (xbn_reg ^ hs_reg[17]) ? -$signed(acc_reg) : $signed(acc_reg);
                    acc_next = '0;
                    mc_next  = {18'b0, ybm_reg};
                    mp_next  = {46'b0, hc_abs};
                end
            end
            ddo_pkg::ST_RY2:
            begin
                if (mul_done)
                begin
                    t_next = (ybn_reg ^ hc_reg[17]) ? t_reg - $signed(acc_reg)
                                                    : t_reg + $signed(acc_reg);
                end
            end
            ddo_pkg::ST_POS_Y:
            begin
                y_next  = pos_sat;
                hd_next = ddo_pkg::wrap_pi(hd_sum);
            end
            ddo_pkg::ST_FINISH:
            begin
                // stage the pose while the previous transaction may still be leaving
                if (out_free)
                begin
                    ox_next = x_reg;
                    oy_next = y_reg;
                    oh_next = hd_reg;
                    ov_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ddo_pkg::ST_IDLE;
            trk_reg    <= ddo_pkg::TRACK_RESET;
            rad_reg    <= ddo_pkg::RADIUS_RESET;
            x_reg      <= '0;
            y_reg      <= '0;
            hd_reg     <= '0;
            last_l_reg <= '0;
            last_r_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            hd_reg     <= hd_next;
            last_l_reg <= last_l_next;
            last_r_reg <= last_r_next;
            ov_reg     <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ddo_pkg::REG_TRACK:  trk_reg <= cfg_data;
                    ddo_pkg::REG_RADIUS: rad_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dl_reg   <= dl_next;   dr_reg   <= dr_next;   ds_reg  <= ds_next;
        wneg_reg <= wneg_next; wm_reg   <= wm_next;
        vm_reg   <= vm_next;   vn_reg   <= vn_next;   ww_reg  <= ww_next;
        s_reg    <= s_next;    c_reg    <= c_next;
        hs_reg   <= hs_next;   hc_reg   <= hc_next;
        xbm_reg  <= xbm_next;  ybm_reg  <= ybm_next;
        xbn_reg  <= xbn_next;  ybn_reg  <= ybn_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;  mc_reg   <= mc_next;   mp_reg  <= mp_next;
        cnt_reg  <= cnt_next;
        ang_reg  <= ang_next;
        cx_reg   <= cx_next;   cy_reg   <= cy_next;   cz_reg  <= cz_next;
        ci_reg   <= ci_next;   flip_reg <= flip_next;
        ox_reg   <= ox_next;   oy_reg   <= oy_next;   oh_reg  <= oh_next;
    end

endmodule

@@ tb/tb_diff_drive_odometry.sv @@
module tb_diff_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W    = ddo_pkg::WORD_W;
    localparam int HEAD_W    = ddo_pkg::HEAD_W;
    localparam int CFG_W     = ddo_pkg::CFG_W;
    localparam int CFG_IDX_W = ddo_pkg::CFG_IDX_W;

    // run limit in cycles, far above the slowest correct run
    localparam int CYCLE_LIMIT = 3000000;
    localparam longint PI_FX = 205887;
    localparam longint ONE_FX = 65536;
    localparam longint ARC_MAX = longint'(1) << 45;

    typedef struct {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [HEAD_W-1:0] h;
    } pose_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ddo_cmd_if cmd_ch ();
    ddo_pose_if pose_ch ();

    diff_drive_odometry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ch    (cmd_ch.sink),
        .pose_ch   (pose_ch.source)
    );

    // mirror of the block: registers and odometry state
    logic [CFG_W-1:0] trk_reg;
    logic [CFG_W-1:0] rad_reg;
    longint px;
    longint py;
    longint ph;
    logic [WORD_W-1:0] last_l;
    logic [WORD_W-1:0] last_r;

    pose_t pending_poses[$];
    int errors;
    int cycles;
    // gap shaping: 0 no gaps, 1 random gaps
    int send_gaps;
    int recv_stalls;

    // ---------------------------------------------------------------
    // fixed point helpers
    // ---------------------------------------------------------------

    // a*b/d truncated toward zero on 64-bit magnitudes
    function automatic longint mul_div(longint a, longint b, longint d);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] md;
        logic [63:0] q;
        bit neg;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        md = d < 0 ? -d : d;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        if (md == 0)
        begin
            return 0;
        end
        q = (ma * mb) / md;
        if (q[63])
        begin
            q = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // fold into [-pi,pi), remainder keeps the dividend sign
    function automatic longint wrap_heading(longint a);
        longint m;
        m = a % (2 * PI_FX);
        if (m >= PI_FX)
        begin
            m -= 2 * PI_FX;
        end
        if (m < -PI_FX)
        begin
            m += 2 * PI_FX;
        end
        return m;
    endfunction

    function automatic longint q30_to_fx(longint v);
        return clamp((v + (longint'(1) << 13)) >>> 14, -ONE_FX, ONE_FX);
    endfunction

    // 30-step rotation-mode cordic in q2.30 with half-plane fold
    task automatic sine_cosine(input longint a, output longint s, output longint c);
        longint z;
        longint cx;
        longint cy;
        longint nx;
        bit flip;
        z = a * (longint'(1) << 14);
        cx = longint'(ddo_pkg::CORDIC_K);
        cy = 0;
        flip = 0;
        if (z > longint'(ddo_pkg::HALF_PI30))
        begin
            z -= longint'(ddo_pkg::PI30);
            flip = 1;
        end
        else if (z < -longint'(ddo_pkg::HALF_PI30))
        begin
            z += longint'(ddo_pkg::PI30);
            flip = 1;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z -= longint'(ddo_pkg::atan_q30(5'(i)));
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z += longint'(ddo_pkg::atan_q30(5'(i)));
            end
            cx = nx;
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        s = q30_to_fx(cy);
        c = q30_to_fx(cx);
    endtask

    // advance the mirrored odometry by one command, return the new pose
    task automatic advance_pose(input logic cmd, input logic [WORD_W-1:0] nl,
                                input logic [WORD_W-1:0] nr, input logic signed [WORD_W-1:0] nx,
                                input logic signed [WORD_W-1:0] ny,
                                input logic signed [HEAD_W-1:0] nh, output pose_t p);
        logic [WORD_W-1:0] dlw;
        logic [WORD_W-1:0] drw;
        longint dl;
        longint dr;
        longint r;
        longint trk;
        longint w;
        longint v;
        longint xb;
        longint yb;
        longint s;
        longint c;
        longint hs;
        longint hc;
        if (cmd == ddo_pkg::CMD_SET)
        begin
            px = longint'(nx);
            py = longint'(ny);
            ph = wrap_heading(longint'(nh));
        end
        else
        begin
            dlw = nl - last_l;
            drw = nr - last_r;
            dl = longint'($signed(dlw));
            dr = longint'($signed(drw));
            r = longint'(rad_reg);
            trk = trk_reg == 0 ? 1 : longint'(trk_reg);
            w = mul_div(r, dr - dl, trk);
            v = (r * (dl + dr)) >>> 17;
            if (w == 0)
            begin
                // exactly straight travel
                xb = v;
                yb = 0;
            end
            else
            begin
                sine_cosine(wrap_heading(w), s, c);
                xb = mul_div(v, s, w);
                yb = mul_div(v, ONE_FX - c, w);
            end
            xb = clamp(xb, -ARC_MAX, ARC_MAX);
            yb = clamp(yb, -ARC_MAX, ARC_MAX);
            sine_cosine(ph, hs, hc);
            px = clamp(px + ((xb * hc - yb * hs) >>> 16), -(longint'(1) << 31),
                       (longint'(1) << 31) - 1);
            py = clamp(py + ((xb * hs + yb * hc) >>> 16), -(longint'(1) << 31),
                       (longint'(1) << 31) - 1);
            ph = wrap_heading(ph + wrap_heading(w));
            last_l = nl;
            last_r = nr;
        end
        p.x = px[31:0];
        p.y = py[31:0];
        p.h = ph[18:0];
    endtask

    // ---------------------------------------------------------------
    // clock, reset, cycle limit
    // ---------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // monitor: check the pose transaction, then predict from the command
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        pose_t exp_p;
        pose_t new_p;
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("pose transaction with nothing expected");
                errors++;
            end
            else
            begin
                exp_p = pending_poses.pop_front();
                if (pose_ch.pose_x !== exp_p.x)
                begin
                    $error("pose_x expected %0d actual %0d", exp_p.x, pose_ch.pose_x);
                    errors++;
                end
                if (pose_ch.pose_y !== exp_p.y)
                begin
                    $error("pose_y expected %0d actual %0d", exp_p.y, pose_ch.pose_y);
                    errors++;
                end
                if (pose_ch.heading !== exp_p.h)
                begin
                    $error("heading expected %0d actual %0d", exp_p.h, pose_ch.heading);
                    errors++;
                end
            end
        end
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            advance_pose(cmd_ch.cmd, cmd_ch.left_wheel_angle, cmd_ch.right_wheel_angle,
                         cmd_ch.new_x, cmd_ch.new_y, cmd_ch.new_heading, new_p);
            pending_poses.push_back(new_p);
        end
    end

    // receiver backpressure: when stalls are enabled, ready drops at random 30 percent of the time
    always @(negedge clk)
    begin
        if (!rst_n || recv_stalls == 0)
        begin
            pose_ch.ready <= 1'b1;
        end
        else if ($urandom_range(99) < 30)
        begin
            pose_ch.ready <= 1'b0;
        end
        else
        begin
            pose_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // driving tasks
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (send_gaps == 0 || roll < 50)
        begin
            return 0;
        end
        return roll < 93 ? $urandom_range(3, 1) : $urandom_range(60, 10);
    endfunction

    // offer one command transaction and hold it until accepted
    task automatic send_cmd(input logic cmd, input logic [WORD_W-1:0] nl,
                            input logic [WORD_W-1:0] nr, input logic [WORD_W-1:0] nx,
                            input logic [WORD_W-1:0] ny, input logic [HEAD_W-1:0] nh);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid = 1'b1;
        cmd_ch.cmd = cmd;
        // unused fields carry noise
        cmd_ch.left_wheel_angle = cmd == ddo_pkg::CMD_WHEEL ? nl : $urandom;
        cmd_ch.right_wheel_angle = cmd == ddo_pkg::CMD_WHEEL ? nr : $urandom;
        cmd_ch.new_x = cmd == ddo_pkg::CMD_SET ? nx : $urandom;
        cmd_ch.new_y = cmd == ddo_pkg::CMD_SET ? ny : $urandom;
        cmd_ch.new_heading = cmd == ddo_pkg::CMD_SET ? nh : HEAD_W'($urandom);
        do
        begin
            @(posedge clk);
        end
        while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    task automatic wheel_step(input logic signed [WORD_W-1:0] dl, input logic signed [WORD_W-1:0] dr);
        send_cmd(ddo_pkg::CMD_WHEEL, last_l + dl, last_r + dr, '0, '0, '0);
    endtask

    task automatic set_pose(input logic [WORD_W-1:0] nx, input logic [WORD_W-1:0] ny,
                            input logic [HEAD_W-1:0] nh);
        send_cmd(ddo_pkg::CMD_SET, '0, '0, nx, ny, nh);
    endtask

    // wait for every pose, the block then sits idle
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_poses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == ddo_pkg::REG_TRACK)
        begin
            trk_reg = val;
        end
        else
        begin
            rad_reg = val;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [HEAD_W-1:0] rand_heading();
        return HEAD_W'(int'($urandom_range(411774)) - 205887);
    endfunction

    // random wheel increment, mostly small, sometimes the full word
    function automatic logic [WORD_W-1:0] rand_delta();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            return WORD_W'(int'($urandom_range(40000)) - 20000);
        end
        if (roll < 85)
        begin
            return WORD_W'(int'($urandom_range(2000000)) - 1000000);
        end
        return $urandom;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_set_pose();
        set_pose(32'h7FFF_FFFF, 32'h8000_0000, 19'(205887));
        set_pose(32'h8000_0000, 32'h7FFF_FFFF, 19'(-205887));
        set_pose('0, '0, 19'h3FFFF);
        set_pose(32'hFFFF_FFFF, 32'h0000_0001, 19'h40000);
        set_pose('0, '0, '0);
    endtask

    task automatic test_wheel_extremes();
        // equal wheels give a straight path
        wheel_step(32'sd65536, 32'sd65536);
        wheel_step('0, '0);
        // spin in place
        wheel_step(-32'sd100000, 32'sd100000);
        // wheel angle wraps across the word boundary
        send_cmd(ddo_pkg::CMD_WHEEL, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0);
        send_cmd(ddo_pkg::CMD_WHEEL, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
        wheel_step(32'sh8000_0000, 32'sh7FFF_FFFF);
        // heading near the pi boundary, then a tiny turn that may round to zero
        set_pose(32'sd1000, -32'sd1000, 19'(205886));
        wheel_step(32'sd10, 32'sd300000);
        wheel_step(32'sd5, 32'sd6);
        set_pose(32'h7FFF_FF00, 32'h7FFF_FF00, 19'(-205887));
        wheel_step(32'sh4000_0000, 32'sh4000_0000);
    endtask

    task automatic test_registers();
        // smallest track and largest radius drive the clamps and saturation
        write_reg(ddo_pkg::REG_TRACK, 31'd1);
        write_reg(ddo_pkg::REG_RADIUS, 31'h7FFF_FFFF);
        wheel_step(32'sd7, -32'sd3);
        wheel_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        wheel_step(32'sh8000_0000, 32'sh8000_0001);
        // zero track behaves as one
        write_reg(ddo_pkg::REG_TRACK, 31'd0);
        wheel_step(32'sd1, 32'sd2);
        write_reg(ddo_pkg::REG_TRACK, 31'h7FFF_FFFF);
        write_reg(ddo_pkg::REG_RADIUS, 31'd1);
        wheel_step(32'sd123456, -32'sd654321);
        write_reg(ddo_pkg::REG_TRACK, ddo_pkg::TRACK_RESET);
        write_reg(ddo_pkg::REG_RADIUS, ddo_pkg::RADIUS_RESET);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                send_gaps = $urandom_range(1);
                recv_stalls = $urandom_range(1);
            end
            if ($urandom_range(99) < 12)
            begin
                set_pose($urandom_range(99) < 70 ? WORD_W'(int'($urandom_range(2000000)) - 1000000)
                                                 : $urandom,
                         $urandom_range(99) < 70 ? WORD_W'(int'($urandom_range(2000000)) - 1000000)
                                                 : $urandom,
                         rand_heading());
            end
            else
            begin
                wheel_step(rand_delta(), rand_delta());
            end
        end
    endtask

    task automatic test_random_settings();
        write_reg(ddo_pkg::REG_TRACK, CFG_W'($urandom_range(200000, 1000)));
        write_reg(ddo_pkg::REG_RADIUS, CFG_W'($urandom_range(20000, 100)));
        test_random(80);
        write_reg(ddo_pkg::REG_TRACK, CFG_W'($urandom));
        write_reg(ddo_pkg::REG_RADIUS, CFG_W'($urandom));
        test_random(40);
        write_reg(ddo_pkg::REG_TRACK, ddo_pkg::TRACK_RESET);
        write_reg(ddo_pkg::REG_RADIUS, ddo_pkg::RADIUS_RESET);
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        errors = 0;
        cycles = 0;
        send_gaps = 1;
        recv_stalls = 1;
        trk_reg = ddo_pkg::TRACK_RESET;
        rad_reg = ddo_pkg::RADIUS_RESET;
        px = 0;
        py = 0;
        ph = 0;
        last_l = '0;
        last_r = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ddo_pkg::REG_TRACK;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = ddo_pkg::CMD_WHEEL;
        cmd_ch.left_wheel_angle = '0;
        cmd_ch.right_wheel_angle = '0;
        cmd_ch.new_x = '0;
        cmd_ch.new_y = '0;
        cmd_ch.new_heading = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_set_pose();
        test_wheel_extremes();
        // sender holds off until every pose is back
        drain();
        test_registers();
        test_random(180);
        test_random_settings();

        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && pending_poses.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ diff_drive_odometry.f @@
design/ddo_pkg.sv
design/ddo_if.sv
design/diff_drive_odometry.sv
tb/tb_diff_drive_odometry.sv
